>>> sv/ssd_pkg.sv
// Package: payload types, constants and font tables for the segment display core.
package ssd_pkg;

   localparam int DefNumDigits = 5;
   localparam int FrameWidth   = 43;
   localparam int TagWidth     = 3;

   localparam logic [1:0] FUNC_WRITE_CURSOR = 2'd0;
   localparam logic [1:0] FUNC_WRITE_POS    = 2'd1;
   localparam logic [1:0] FUNC_SET_ALL      = 2'd2;
   localparam logic [1:0] FUNC_CLEAR        = 2'd3;

   localparam logic [6:0] CHAR_MASK  = 7'b1111111;
   localparam logic [7:0] DOT_BIT    = 8'b00000001;
   localparam logic [7:0] ALL_ON     = 8'b11111111;
   localparam logic [6:0] COMMA_CODE = 7'h2C;
   localparam logic [TagWidth-1:0] TAG_A = 3'd0;
   localparam logic [TagWidth-1:0] TAG_B = 3'd1;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] position;
      logic [7:0] character;
      logic       level;
   } req_word_type;

   typedef struct packed {
      logic [FrameWidth-1:0] frame_word;
      logic                  last;
   } rsp_word_type;

   localparam logic [7:0] FONT_A [128] = '{
      8'h00,8'hE2,8'h1E,8'h42,8'h1C,8'h4A,8'h16,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h08,8'h20,8'h32,8'h7A,8'h32,8'h2E,8'h00,
      8'h00,8'h00,8'h02,8'h02,8'h00,8'h02,8'h01,8'h00,
      8'hFC,8'h90,8'hCE,8'hD8,8'hB2,8'h7A,8'h7E,8'hD0,
      8'hFE,8'hFA,8'h00,8'h01,8'h00,8'h0A,8'h00,8'hE1,
      8'hEC,8'hF6,8'hD8,8'h6C,8'hD8,8'h6E,8'h66,8'h7C,
      8'hB6,8'h48,8'h9C,8'h26,8'h2C,8'hB4,8'hB4,8'hFC,
      8'hE6,8'hFC,8'hE6,8'h7A,8'h40,8'hBC,8'h24,8'hBC,
      8'h00,8'h00,8'h48,8'h6C,8'h00,8'hD8,8'h00,8'h08,
      8'h00,8'hF6,8'h3E,8'h0E,8'h9E,8'hEE,8'h66,8'hFA,
      8'h26,8'h0A,8'h98,8'h26,8'h24,8'h16,8'h06,8'h1E,
      8'hE6,8'hF2,8'h00,8'h08,8'h2E,8'h1C,8'h04,8'h14,
      8'h00,8'h90,8'h0A,8'h02,8'h00,8'h00,8'h30,8'hFF
   };

   localparam logic [7:0] FONT_B [128] = '{
      8'h00,8'hE2,8'h1E,8'h42,8'h1C,8'h4A,8'h16,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h48,8'h40,8'h4A,8'h4A,8'hCE,8'h48,8'h40,
      8'h90,8'h24,8'hFE,8'h4A,8'h00,8'h02,8'h00,8'h84,
      8'h00,8'h00,8'h02,8'h02,8'h02,8'h02,8'h02,8'h00,
      8'h02,8'h02,8'h01,8'h01,8'h90,8'h02,8'h24,8'h0A,
      8'h42,8'h02,8'h4A,8'h00,8'h48,8'h00,8'h00,8'h02,
      8'h02,8'h48,8'h00,8'h90,8'h00,8'hA0,8'h30,8'h00,
      8'h02,8'h10,8'h12,8'h02,8'h48,8'h00,8'h84,8'h08,
      8'hB4,8'hA8,8'h84,8'h00,8'h30,8'h00,8'hA0,8'h00,
      8'h20,8'h02,8'h02,8'h02,8'h02,8'h02,8'h00,8'h02,
      8'h08,8'h0A,8'h00,8'h12,8'h00,8'h0A,8'h08,8'h02,
      8'h02,8'h02,8'h0A,8'h12,8'h00,8'h00,8'h04,8'h14,
      8'hB4,8'h42,8'h04,8'h90,8'h48,8'h26,8'h30,8'hFF
   };

endpackage

>>> sv/scrolling_segment_text_display_core.sv
// Top level: command decode, digit store and two-frame output for the segment display.
// The A frame shows in the cycle after a command word is taken, the B frame once the A
//   frame is accepted. The single frame register carries the A and then the B frame;
//   a new command is taken in the cycle the B frame is accepted, and is held off while
//   either frame of the last command still waits.
// Reset: synchronous, active high; clears all digit bytes, sets the cursor to one
//   and empties the frame register.
module scrolling_segment_text_display_core
   import ssd_pkg::*;
#(
   parameter int NUM_DIGITS = DefNumDigits
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int CurW = $clog2(NUM_DIGITS + 2);
   localparam int IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [CurW-1:0] CUR_ONE  = CurW'(1);
   localparam logic [CurW-1:0] CUR_LAST = CurW'(NUM_DIGITS);

   logic [7:0] seg_a_ff [NUM_DIGITS];
   logic [7:0] seg_b_ff [NUM_DIGITS];
   logic [7:0] seg_a_in [NUM_DIGITS];
   logic [7:0] seg_b_in [NUM_DIGITS];
   logic [CurW-1:0] cursor_ff, cursor_in;

   // Output: rsp register holds the current frame; b_pend_ff means the B frame of
   // the same command is still owed, its bytes parked in b_hold_ff.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  b_pend_ff, b_pend_in;
   rsp_word_type          rsp_ff, rsp_in;
   logic [FrameWidth-1:0] b_hold_ff, b_hold_in;

   logic       take;
   logic       rsp_free;
   logic [6:0] ch;
   logic [7:0] ga, gb;
   logic [CurW-1:0] pos_w, cur_w;
   logic            pos_ok;
   logic [FrameWidth-1:0] frame_a, frame_b;

   // Accept a command only when the frame register will be free of both frames.
   assign rsp_free  = !rsp_valid_ff || (!rsp_stall && !b_pend_ff);
   assign req_stall = !rsp_free;
   assign take      = req_valid && rsp_free;

   assign ch = req_word.character[6:0] & CHAR_MASK;
   assign ga = FONT_A[ch];
   assign gb = FONT_B[ch];

   always_comb begin
      logic [IdxW-1:0] slot;
      logic            no_dot;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         seg_a_in[k] = seg_a_ff[k];
         seg_b_in[k] = seg_b_ff[k];
      end
      cursor_in = cursor_ff;
      pos_w     = CurW'(req_word.position);
      cur_w     = cursor_ff;
      pos_ok    = 1'b0;
      slot      = '0;
      no_dot    = ((ga | gb) & DOT_BIT) == 8'h00;
      if (take) begin
         unique case (req_word.func)
            FUNC_WRITE_CURSOR: begin
               // Scroll left when the cursor has run past the last digit.
               if (cursor_ff > CUR_LAST) begin
                  for (int k = 0; k + 1 < NUM_DIGITS; k++) begin
                     seg_a_in[k] = seg_a_ff[k+1];
                     seg_b_in[k] = seg_b_ff[k+1];
                  end
                  cur_w = CUR_LAST;
               end
               pos_w  = cur_w;
               pos_ok = (cur_w >= CUR_ONE) && (cur_w <= CUR_LAST);
            end
            FUNC_WRITE_POS: begin
               pos_w  = (CurW >= 3) ? CurW'(req_word.position)
                                    : CurW'(req_word.position);
               pos_ok = (req_word.position != 3'd0) &&
                        ({29'd0, req_word.position} <= 32'(NUM_DIGITS));
            end
            FUNC_SET_ALL: begin
               for (int k = 0; k < NUM_DIGITS; k++) begin
                  seg_a_in[k] = req_word.level ? ALL_ON : 8'h00;
                  seg_b_in[k] = req_word.level ? ALL_ON : 8'h00;
               end
            end
            FUNC_CLEAR: begin
               for (int k = 0; k < NUM_DIGITS; k++) begin
                  seg_a_in[k] = 8'h00;
                  seg_b_in[k] = 8'h00;
               end
               cursor_in = CUR_ONE;
            end
            default: ;
         endcase
         if (req_word.func == FUNC_WRITE_CURSOR) begin
            cursor_in = cur_w;
         end
         if (pos_ok) begin
            slot = IdxW'(pos_w - CUR_ONE);
            if (ch == COMMA_CODE) begin
               seg_a_in[slot] = seg_a_in[slot] & ~DOT_BIT;
               seg_b_in[slot] = seg_b_in[slot] & ~DOT_BIT;
            end else begin
               seg_a_in[slot] = (seg_a_in[slot] & DOT_BIT) | ga;
               seg_b_in[slot] = (seg_b_in[slot] & DOT_BIT) | gb;
               // Advance past dot-free glyphs, saturating one beyond the last digit.
               if (no_dot && (cursor_in <= CUR_LAST)) begin
                  cursor_in = cursor_in + CUR_ONE;
               end
            end
         end
      end
   end

   // Pack digits highest first; bytes beyond the frame drop off the top.
   always_comb begin
      logic [8*NUM_DIGITS+TagWidth-1:0] wa, wb;
      for (int k = 0; k < NUM_DIGITS; k++) begin
         wa[TagWidth+8*k +: 8] = seg_a_in[k];
         wb[TagWidth+8*k +: 8] = seg_b_in[k];
      end
      wa[TagWidth-1:0] = TAG_A;
      wb[TagWidth-1:0] = TAG_B;
      frame_a = FrameWidth'(wa);
      frame_b = FrameWidth'(wb);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      b_pend_in    = b_pend_ff;
      rsp_in       = rsp_ff;
      b_hold_in    = b_hold_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         if (b_pend_ff) begin
            rsp_in.frame_word = b_hold_ff;
            rsp_in.last       = 1'b1;
            b_pend_in         = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (take) begin
         rsp_valid_in      = 1'b1;
         b_pend_in         = 1'b1;
         rsp_in.frame_word = frame_a;
         rsp_in.last       = 1'b0;
         b_hold_in         = frame_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_DIGITS; k++) begin
            seg_a_ff[k] <= 8'h00;
            seg_b_ff[k] <= 8'h00;
         end
         cursor_ff    <= CUR_ONE;
         rsp_valid_ff <= 1'b0;
         b_pend_ff    <= 1'b0;
      end else begin
         for (int k = 0; k < NUM_DIGITS; k++) begin
            seg_a_ff[k] <= seg_a_in[k];
            seg_b_ff[k] <= seg_b_in[k];
         end
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         b_pend_ff    <= b_pend_in;
      end
      rsp_ff    <= rsp_in;
      b_hold_ff <= b_hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

>>> tb/scrolling_segment_text_display_core_tb.sv
// Testbench: drives display commands and checks both segment frames against a local model.
module scrolling_segment_text_display_core_tb;
   import ssd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Digits = DefNumDigits;

   typedef enum int {
      PH_NO_IDLE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD_OFF
   } phase_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   scrolling_segment_text_display_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   // Display model: segment bytes per digit (index 0 is digit 1) and the cursor.
   logic [7:0] seg_a [Digits];
   logic [7:0] seg_b [Digits];
   int unsigned text_cursor;

   req_word_type command_queue[$];
   rsp_word_type frame_queue[$];
   int           mismatch_count;
   int           idle_pct_send;
   int           idle_pct_recv;
   int           hold_off_cycles;

   always #6 clock = ~clock;

   // Put one glyph into the digit at pos; a comma clears only the dots.
   task automatic place_glyph(input int unsigned pos, input logic [7:0] ch);
      int unsigned slot;
      logic [6:0]  code;
      logic [7:0]  ga;
      logic [7:0]  gb;
      if (pos < 1 || pos > Digits) return;
      slot = pos - 1;
      code = ch[6:0] & CHAR_MASK;
      if (code == COMMA_CODE) begin
         seg_a[slot] &= ~DOT_BIT;
         seg_b[slot] &= ~DOT_BIT;
         return;
      end
      ga = FONT_A[code];
      gb = FONT_B[code];
      // Dotted glyphs hold the cursor; advance saturates one past the end.
      if (((ga | gb) & DOT_BIT) == 0 && text_cursor <= Digits) text_cursor++;
      seg_a[slot] = (seg_a[slot] & DOT_BIT) | ga;
      seg_b[slot] = (seg_b[slot] & DOT_BIT) | gb;
   endtask

   function automatic logic [FrameWidth-1:0] pack_frame(input bit half_b,
                                                        input logic [TagWidth-1:0] tag);
      logic [63:0] w;
      w = 0;
      for (int k = Digits; k > 0; k--) w = (w << 8) | (half_b ? seg_b[k-1] : seg_a[k-1]);
      w = (w << TagWidth) | tag;
      return w[FrameWidth-1:0];
   endfunction

   // Apply one command to the display model and queue its two frames.
   task automatic apply_command(input req_word_type c);
      rsp_word_type f;
      case (c.func)
         FUNC_WRITE_CURSOR: begin
            // Scroll left when the cursor has run past the last digit.
            if (text_cursor > Digits) begin
               for (int k = 0; k + 1 < Digits; k++) begin
                  seg_a[k] = seg_a[k+1];
                  seg_b[k] = seg_b[k+1];
               end
               text_cursor = Digits;
            end
            place_glyph(text_cursor, c.character);
         end
         FUNC_WRITE_POS: place_glyph(32'(c.position), c.character);
         FUNC_SET_ALL: begin
            for (int k = 0; k < Digits; k++) begin
               seg_a[k] = c.level ? ALL_ON : 8'h00;
               seg_b[k] = c.level ? ALL_ON : 8'h00;
            end
         end
         default: begin
            for (int k = 0; k < Digits; k++) begin
               seg_a[k] = 8'h00;
               seg_b[k] = 8'h00;
            end
            text_cursor = 1;
         end
      endcase
      f.frame_word = pack_frame(1'b0, TAG_A);
      f.last = 1'b0;
      frame_queue.push_back(f);
      f.frame_word = pack_frame(1'b1, TAG_B);
      f.last = 1'b1;
      frame_queue.push_back(f);
   endtask

   // Driver: present the next pending word; advance when accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_command(req_word);
         if (!req_valid || !req_stall) begin
            if (command_queue.size() > 0 && $urandom_range(99) >= idle_pct_send) begin
               req_word  <= command_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random per phase, or a long counted hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct_recv);
      end
   end

   // Monitor: compare every accepted frame with the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected frame %h last %b",
                                               rsp_word.frame_word, rsp_word.last);
         end else begin
            want = frame_queue.pop_front();
            if (want.frame_word !== rsp_word.frame_word || want.last !== rsp_word.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("frame mismatch: expected %h last %b, got %h last %b",
                           want.frame_word, want.last, rsp_word.frame_word, rsp_word.last);
            end
         end
      end
   end

   function automatic req_word_type make_command(input logic [1:0] f, input logic [2:0] p,
                                                 input logic [7:0] ch, input logic lv);
      req_word_type c;
      c.func = f;
      c.position = p;
      c.character = ch;
      c.level = lv;
      return c;
   endfunction

   // Mostly text at the cursor so the scroll path is exercised often.
   function automatic req_word_type random_command();
      int unsigned r;
      logic [7:0]  ch;
      logic [2:0]  p;
      logic        lv;
      r  = $urandom_range(99);
      ch = 8'($urandom_range(255));
      p  = 3'($urandom_range(7));
      lv = 1'($urandom_range(1));
      if ($urandom_range(9) == 0) ch = {ch[7], 7'h2C};
      if (r < 60) return make_command(FUNC_WRITE_CURSOR, p, ch, lv);
      if (r < 85) return make_command(FUNC_WRITE_POS, p, ch, lv);
      if (r < 93) return make_command(FUNC_SET_ALL, p, ch, lv);
      return make_command(FUNC_CLEAR, p, ch, lv);
   endfunction

   task automatic wait_drained();
      while (command_queue.size() > 0 || req_valid || frame_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      phase_type ph;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      mismatch_count = 0;
      idle_pct_send = 0;
      idle_pct_recv = 0;
      hold_off_cycles = 0;
      for (int k = 0; k < Digits; k++) begin
         seg_a[k] = 8'h00;
         seg_b[k] = 8'h00;
      end
      text_cursor = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: fill past the end to scroll, dotted glyphs, comma, bad positions.
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, "A", 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 7, 8'hC2, 1));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, 8'h2E, 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, "C", 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, 8'hAC, 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, "D", 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, "E", 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, 8'h7F, 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, "F", 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, "G", 0));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, 8'hFF, 1));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 0, "H", 0));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 6, "H", 0));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 7, "H", 1));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 1, 8'h3B, 0));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 5, 8'h2C, 0));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 1, 8'h2C, 0));
      command_queue.push_back(make_command(FUNC_SET_ALL, 0, 8'h00, 1));
      command_queue.push_back(make_command(FUNC_WRITE_POS, 3, 8'h2C, 0));
      command_queue.push_back(make_command(FUNC_SET_ALL, 7, 8'hFF, 0));
      command_queue.push_back(make_command(FUNC_CLEAR, 7, 8'hFF, 1));
      command_queue.push_back(make_command(FUNC_WRITE_CURSOR, 0, 8'h00, 0));
      wait_drained();

      // Random phases with different idling mixes, then one long hold-off.
      for (int p = 0; p < 5; p++) begin
         ph = phase_type'(p);
         case (ph)
            PH_NO_IDLE:    begin idle_pct_send = 0;  idle_pct_recv = 0;  end
            PH_SEND_IDLE:  begin idle_pct_send = 46; idle_pct_recv = 0;  end
            PH_RECV_STALL: begin idle_pct_send = 0;  idle_pct_recv = 46; end
            PH_BOTH:       begin idle_pct_send = 8;  idle_pct_recv = 8;  end
            default:       begin idle_pct_send = 0;  idle_pct_recv = 0;  end
         endcase
         for (int i = 0; i < 200; i++) command_queue.push_back(random_command());
         if (ph == PH_HOLD_OFF) begin
            @(posedge clock);
            hold_off_cycles <= 300;
         end
         // Sender pauses here until every frame has come back.
         wait_drained();
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && frame_queue.size() == 0) begin
         $display("PASS scrolling_segment_text_display_core");
      end else begin
         $display("FAIL scrolling_segment_text_display_core");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL scrolling_segment_text_display_core");
      $finish;
   end

endmodule
